>>> rtl/efm_pkg.sv
// Shared types, constants and the type-mapping function for the EFI-to-E820 merge block.
// Used by efm_merge, efm_rqueue and efi_map_to_e820_merge_core; no dependencies.
package efm_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int ENT_W       = $clog2(MAX_ENTRIES);
  localparam int PAGE_BITS   = 12;
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_AW       = $clog2(RQ_DEPTH);
  localparam int RES_SLOTS   = 3;

  localparam logic [ENT_W-1:0] ENT_LIMIT = ENT_W'(MAX_ENTRIES - 1);

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_RAM      = 3'd1;
  localparam logic [2:0] KIND_RESERVED = 3'd2;
  localparam logic [2:0] KIND_ACPI     = 3'd3;
  localparam logic [2:0] KIND_NVS      = 3'd4;
  localparam logic [2:0] KIND_UNUSABLE = 3'd5;

  localparam logic REG_HV_BASE = 1'b0;
  localparam logic REG_HV_SIZE = 1'b1;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [2:0]  kind;
    logic        err;
    logic        last;
  } e820_res_t;

  // Results caused by one request: slot 0 first, cnt slots valid.
  typedef struct packed {
    e820_res_t [RES_SLOTS-1:0] res;
    logic [1:0]                cnt;
  } res_group_t;

  function automatic logic [2:0] kind_of_type(input logic [3:0] efi_type);
    logic [2:0] k;
    case (efi_type)
      4'd0, 4'd5, 4'd6, 4'd11, 4'd12, 4'd13: k = KIND_RESERVED;
      4'd1, 4'd2, 4'd3, 4'd4, 4'd7:          k = KIND_RAM;
      4'd8:                                  k = KIND_UNUSABLE;
      4'd9:                                  k = KIND_ACPI;
      4'd10:                                 k = KIND_NVS;
      default:                               k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/efm_merge.sv
// Pending-entry state and the per-descriptor merge / flush / overflow decision.
// Depends on efm_pkg; produces up to three results per accepted request.
module efm_merge import efm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [3:0]  efi_type_i,
  input  logic [63:0] phys_start_i,
  input  logic [51:0] page_count_i,
  input  logic        map_end_i,
  input  logic [63:0] hv_base_i,
  input  logic [63:0] hv_size_i,
  output res_group_t  grp_o
);

  logic             pend_valid_q, pend_valid_d;
  logic [63:0]      pend_base_q, pend_base_d;
  logic [63:0]      pend_length_q, pend_length_d;
  logic [2:0]       pend_kind_q, pend_kind_d;
  logic [ENT_W-1:0] entries_q, entries_d;
  logic             error_seen_q, error_seen_d;

  logic [2:0]  kind;
  logic [63:0] len;
  logic        merge;
  res_group_t  grp;

  assign kind  = kind_of_type(efi_type_i);
  assign len   = {page_count_i, {PAGE_BITS{1'b0}}};
  assign merge = pend_valid_q && (pend_kind_q == kind) &&
                 ((pend_base_q + pend_length_q) == phys_start_i);

  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_base_d   = pend_base_q;
    pend_length_d = pend_length_q;
    pend_kind_d   = pend_kind_q;
    entries_d     = entries_q;
    error_seen_d  = error_seen_q;
    grp           = '0;

    if (take_i) begin
      if (error_seen_q) begin
        // drop the rest of the map until its final descriptor
        if (map_end_i) begin
          pend_valid_d = 1'b0;
          entries_d    = '0;
          error_seen_d = 1'b0;
        end
      end else if (entries_q >= ENT_LIMIT) begin
        grp.res[0].base   = '0;
        grp.res[0].length = '0;
        grp.res[0].kind   = KIND_NONE;
        grp.res[0].err    = 1'b1;
        grp.res[0].last   = 1'b1;
        grp.cnt           = 2'd1;
        pend_valid_d      = 1'b0;
        entries_d         = '0;
        error_seen_d      = !map_end_i;
      end else begin
        if (kind != KIND_NONE) begin
          if (merge) begin
            pend_length_d = pend_length_q + len;
          end else begin
            if (pend_valid_q) begin
              grp.res[grp.cnt] = '{pend_base_q, pend_length_q, pend_kind_q, 1'b0, 1'b0};
              grp.cnt          = grp.cnt + 2'd1;
            end
            pend_valid_d  = 1'b1;
            pend_base_d   = phys_start_i;
            pend_length_d = len;
            pend_kind_d   = kind;
            entries_d     = entries_q + ENT_W'(1);
          end
        end
        if (map_end_i) begin
          if (pend_valid_d) begin
            grp.res[grp.cnt] = '{pend_base_d, pend_length_d, pend_kind_d, 1'b0, 1'b0};
            grp.cnt          = grp.cnt + 2'd1;
          end
          grp.res[grp.cnt] = '{hv_base_i, hv_size_i, KIND_RAM, 1'b0, 1'b1};
          grp.cnt          = grp.cnt + 2'd1;
          pend_valid_d     = 1'b0;
          entries_d        = '0;
        end
      end
    end
  end

  assign grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_base_q   <= '0;
      pend_length_q <= '0;
      pend_kind_q   <= KIND_NONE;
      entries_q     <= '0;
      error_seen_q  <= 1'b0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      pend_base_q   <= pend_base_d;
      pend_length_q <= pend_length_d;
      pend_kind_q   <= pend_kind_d;
      entries_q     <= entries_d;
      error_seen_q  <= error_seen_d;
    end
  end

endmodule

>>> rtl/efm_rqueue.sv
// Result queue: takes up to three results per cycle, hands out one per cycle while ready_i is high.
// Depends on efm_pkg; the head entry is the registered output.
module efm_rqueue import efm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_group_t grp_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output e820_res_t  head_o
);

  e820_res_t            q_q [RQ_DEPTH];
  logic [RQ_AW-1:0]     wr_q, rd_q;
  logic [RQ_AW:0]       cnt_q;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign head_o  = q_q[rd_q];
  // leave space for the largest group a request can cause
  assign room_o  = (cnt_q <= (RQ_AW+1)'(RQ_DEPTH - RES_SLOTS));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_SLOTS; i++) begin
      if (2'(i) < grp_i.cnt) begin
        q_q[wr_q + RQ_AW'(i)] <= grp_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + RQ_AW'(grp_i.cnt);
      rd_q  <= rd_q + RQ_AW'(pop);
      cnt_q <= cnt_q + (RQ_AW+1)'(grp_i.cnt) - (RQ_AW+1)'(pop);
    end
  end

endmodule

>>> rtl/efi_map_to_e820_merge_core.sv
// Top level: EFI memory descriptors in, merged E820 entries out.
// Depends on efm_pkg, efm_merge and efm_rqueue.
//
//  channel   | direction | handshake              | contents
//  s_axis    | in        | tvalid/tready          | one EFI descriptor, tlast = end of map
//  m_axis    | out       | tvalid/tready          | one E820 entry, tlast = final entry
//  cfg       | in        | cfg_we_i (no wait)     | hypervisor region base / size
//
// One descriptor per cycle is accepted while there is room; its results (up to three)
// appear from the next cycle, one per cycle while m_axis_tready is high, through a
// four-entry result queue. Input is held off only while the queue cannot take a full
// group of three, so the output port sets the sustained rate. Reset clears the pending
// entry, entry count, error flag and queue; output stalls back up into s_axis_tready.
module efi_map_to_e820_merge_core import efm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,   // [63:0] phys_start, [115:64] page_count, rest 0
  input  logic [3:0]   s_axis_tuser,   // [3:0] efi_type
  input  logic         s_axis_tlast,   // map_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] out_base, [127:64] out_length
  output logic [3:0]   m_axis_tuser,   // [2:0] out_kind, [3] overflow_error
  output logic         m_axis_tlast,   // last_entry
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  logic [63:0] hv_base_q, hv_size_q;
  logic        room;
  logic        take;
  res_group_t  grp;
  e820_res_t   head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_base_q <= '0;
      hv_size_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HV_BASE: hv_base_q <= cfg_data_i;
        REG_HV_SIZE: hv_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  efm_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .efi_type_i   (s_axis_tuser),
    .phys_start_i (s_axis_tdata[63:0]),
    .page_count_i (s_axis_tdata[115:64]),
    .map_end_i    (s_axis_tlast),
    .hv_base_i    (hv_base_q),
    .hv_size_i    (hv_size_q),
    .grp_o        (grp)
  );

  efm_rqueue u_rqueue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .grp_i   (grp),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {head.length, head.base};
  assign m_axis_tuser = {head.err, head.kind};
  assign m_axis_tlast = head.last;

endmodule

>>> tb/efi_map_to_e820_merge_core_tb.sv
// Testbench for efi_map_to_e820_merge_core: random and directed EFI memory maps in,
// merged E820 entries checked against an in-bench model of the merge rules.
// Depends on efm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module efi_map_to_e820_merge_core_tb;
  import efm_pkg::*;

  // Holds the expected E820 table and the merge state of the map in progress.
  class e820_table_sb;
    e820_res_t   entries_due[$];
    int          errors;
    logic [63:0] hv_base;
    logic [63:0] hv_size;
    logic        open_valid;
    logic [63:0] open_base;
    logic [63:0] open_len;
    logic [2:0]  open_kind;
    int          entries_used;
    logic        map_failed;

    function new();
      errors = 0;
      hv_base = '0;
      hv_size = '0;
      clear_map();
    endfunction

    function void clear_map();
      open_valid = 1'b0;
      open_base = '0;
      open_len = '0;
      open_kind = KIND_NONE;
      entries_used = 0;
      map_failed = 1'b0;
    endfunction

    function void set_region(logic [63:0] b, logic [63:0] s);
      hv_base = b;
      hv_size = s;
    endfunction

    function int outstanding();
      return entries_due.size();
    endfunction

    function logic [2:0] e820_kind(logic [3:0] efi_type);
      case (efi_type)
        4'd1, 4'd2, 4'd3, 4'd4, 4'd7: return KIND_RAM;
        4'd8:  return KIND_UNUSABLE;
        4'd9:  return KIND_ACPI;
        4'd10: return KIND_NVS;
        4'd14, 4'd15: return KIND_NONE;
        default: return KIND_RESERVED;
      endcase
    endfunction

    function void push(logic [63:0] b, logic [63:0] l, logic [2:0] k, logic e, logic f);
      e820_res_t r;
      r.base = b;
      r.length = l;
      r.kind = k;
      r.err = e;
      r.last = f;
      entries_due.push_back(r);
    endfunction

    function void note_descriptor(logic [3:0] efi_type, logic [63:0] start,
                                  logic [51:0] pages, logic map_end);
      logic [63:0] len;
      logic [2:0]  k;
      len = {pages, 12'b0};
      if (map_failed) begin
        if (map_end) clear_map();
        return;
      end
      if (entries_used >= MAX_ENTRIES - 1) begin
        push('0, '0, KIND_NONE, 1'b1, 1'b1);
        clear_map();
        if (!map_end) map_failed = 1'b1;
        return;
      end
      k = e820_kind(efi_type);
      if (k != KIND_NONE) begin
        if (open_valid && open_kind == k && open_base + open_len == start) begin
          open_len = open_len + len;
        end else begin
          if (open_valid) push(open_base, open_len, open_kind, 1'b0, 1'b0);
          open_valid = 1'b1;
          open_base = start;
          open_len = len;
          open_kind = k;
          entries_used = (entries_used + 1) & 8'hFF;
        end
      end
      if (map_end) begin
        if (open_valid) push(open_base, open_len, open_kind, 1'b0, 1'b0);
        // the hypervisor region always stands as an entry of its own
        push(hv_base, hv_size, KIND_RAM, 1'b0, 1'b1);
        clear_map();
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_entry(e820_res_t got);
      e820_res_t want;
      if (entries_due.size() == 0) begin
        report($sformatf("unexpected entry base=%h len=%h kind=%0d", got.base,
                         got.length, got.kind));
        return;
      end
      want = entries_due.pop_front();
      if (got.base !== want.base)
        report($sformatf("base %h, expected %h", got.base, want.base));
      if (got.length !== want.length)
        report($sformatf("length %h, expected %h", got.length, want.length));
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.err !== want.err)
        report($sformatf("overflow flag %b, expected %b", got.err, want.err));
      if (got.last !== want.last)
        report($sformatf("last flag %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [3:0]   s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [63:0]  cfg_data_i;

  e820_table_sb sb;
  int           gap_pct;
  int           stall_pct;
  int           items_sent;
  logic [63:0]  next_addr;
  logic [3:0]   prev_type;

  efi_map_to_e820_merge_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("efi_map_to_e820_merge_core_tb: errors");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    e820_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready && sb != null) begin
      got.base = m_axis_tdata[63:0];
      got.length = m_axis_tdata[127:64];
      got.kind = m_axis_tuser[2:0];
      got.err = m_axis_tuser[3];
      got.last = m_axis_tlast;
      sb.check_entry(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Call at a falling edge; returns at the falling edge after the request.
  task automatic send_desc(logic [3:0] ty, logic [63:0] start, logic [51:0] pages,
                           logic fin);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, pages, start};
    s_axis_tuser <= ty;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_descriptor(ty, start, pages, fin);
    items_sent++;
    next_addr = start + {pages, 12'b0};
    prev_type = ty;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every expected entry is out, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.outstanding() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_region(logic [63:0] b, logic [63:0] s);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_HV_BASE;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_idx_i <= REG_HV_SIZE;
    cfg_data_i <= s;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_region(b, s);
    @(negedge clk_i);
  endtask

  task automatic send_random_map();
    int          n;
    int          r;
    logic [3:0]  ty;
    logic [63:0] start;
    logic [51:0] pages;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) ty = prev_type;
      else if (r < 90) ty = 4'($urandom_range(0, 13));
      else ty = 4'($urandom_range(14, 15));
      r = $urandom_range(99);
      if (r < 60) start = next_addr;
      else if (r < 75) start = rand64();
      else if (r < 85)
        start = 64'hFFFF_FFFF_FFF0_0000 + 64'({$urandom_range(0, 255), 12'b0});
      else start = next_addr + 64'({$urandom_range(1, 64), 12'b0});
      r = $urandom_range(99);
      if (r < 70) pages = 52'($urandom_range(0, 64));
      else if (r < 80) pages = '0;
      else if (r < 90) pages = '1;
      else pages = {20'($urandom_range(0, 20'hFFFFF)), $urandom};
      send_desc(ty, start, pages, i == n - 1);
    end
  endtask

  // A map of distinct entries, long enough to reach the entry limit.
  task automatic send_full_map(int count);
    logic [63:0] start;
    for (int i = 0; i < count; i++) begin
      start = next_addr + 64'({$urandom_range(1, 16), 12'b0});
      send_desc(4'($urandom_range(0, 13)), start, 52'($urandom_range(0, 16)),
                i == count - 1);
    end
  endtask

  initial begin
    int goal;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_HV_BASE;
    cfg_data_i = '0;
    gap_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    next_addr = '0;
    prev_type = 4'd7;
    sb = new();
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed maps; the region sits right after the RAM of the last map.
    write_region(64'h0000_0001_0000_0000, 64'h0000_0000_0200_0000);
    send_desc(4'd7, 64'h0, 52'd0, 1'b0);
    send_desc(4'd1, 64'h0, 52'd1, 1'b0);
    send_desc(4'd9, 64'h1000, 52'd2, 1'b0);
    send_desc(4'd10, 64'h3000, 52'd1, 1'b0);
    send_desc(4'd8, 64'h4000, 52'd3, 1'b0);
    send_desc(4'd14, 64'h5555_AAAA_5555_A000, 52'h5_5555_5555_5555, 1'b0);
    send_desc(4'd0, 64'h7000, 52'd1, 1'b0);
    send_desc(4'd5, 64'h8000, 52'd1, 1'b0);
    send_desc(4'd6, 64'h9000, 52'd1, 1'b0);
    send_desc(4'd11, 64'hA000, 52'd1, 1'b0);
    send_desc(4'd12, 64'hB000, 52'd1, 1'b0);
    send_desc(4'd13, 64'hC000, 52'd1, 1'b0);
    send_desc(4'd2, 64'hD000, 52'd1, 1'b0);
    send_desc(4'd3, 64'hE000, 52'd1, 1'b0);
    send_desc(4'd4, 64'hF000, 52'd1, 1'b0);
    // merge across the top of the address space, length wraps to zero
    send_desc(4'd7, 64'hFFFF_FFFF_FFFF_F000, 52'd1, 1'b0);
    send_desc(4'd7, 64'h0, 52'hF_FFFF_FFFF_FFFF, 1'b0);
    send_desc(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 1'b1);
    send_desc(4'd13, 64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 1'b1);
    send_desc(4'd15, 64'h0, 52'd0, 1'b1);
    send_desc(4'd7, 64'h0000_0000_FFFF_F000, 52'd1, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          gap_pct = 24;
          stall_pct = 79;
          write_region(rand64(), rand64());
        end
        1: begin
          gap_pct = 79;
          stall_pct = 24;
          write_region('1, '1);
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
          write_region('0, '0);
        end
      endcase
      goal = items_sent + 8;
      while (items_sent < goal) begin
        send_random_map();
        if ($urandom_range(7) == 0) wait_drained();
      end
      // fill exactly to the limit, one past it on the last request, then past it mid-map
      case (ph)
        0: send_full_map(MAX_ENTRIES - 1);
        1: send_full_map(MAX_ENTRIES);
        default: send_full_map($urandom_range(MAX_ENTRIES + 4, MAX_ENTRIES + 12));
      endcase
      goal = items_sent + 3;
      while (items_sent < goal) send_random_map();
    end

    wait_drained();
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d entries never arrived", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("efi_map_to_e820_merge_core_tb: clean");
    end else begin
      $display("efi_map_to_e820_merge_core_tb: errors");
    end
    $finish;
  end

endmodule
